>>> rtl/core/e2q_pkg.sv
// Shared constants and elaboration-time helpers for the Euler angle to quaternion core.
// Holds the parameter defaults and the function that builds the quarter-wave sine table.
// No dependencies.
package e2q_pkg;

    // Default configuration of the core.
    localparam int E2Q_ANGLE_BITS       = 16;
    localparam int E2Q_TABLE_INDEX_BITS = 10;
    localparam int E2Q_FRAC_BITS        = 15;

    // Pi over two in unsigned Q2.62.
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

    // Low 64 bits of (a * b) >> s, exact over a 128-bit product.
    function automatic logic [63:0] e2q_mul_shr(input logic [63:0] a, input logic [63:0] b,
                                                input int s);
        logic [127:0] p;
        logic [127:0] q;
        p = {64'd0, a} * {64'd0, b};
        q = p >> s;
        return q[63:0];
    endfunction

    // Entry k of the quarter-wave table: round(2^fb * sin(k*pi/2^(tib+1))), saturated
    // to 2^fb - 1. Evaluated only while the design elaborates.
    function automatic logic [31:0] e2q_sin_entry(input int k, input int tib, input int fb);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] ent;
        logic [63:0] lim;
        x    = e2q_mul_shr(HALF_PI_Q62, 64'(k), tib);
        term = x;
        sum  = x;
        // Taylor series of the sine, alternating terms.
        for (int n = 1; n <= 13; n++) begin
            term = e2q_mul_shr(term, x, 62);
            term = e2q_mul_shr(term, x, 62);
            term = term / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        ent = (sum + (64'd1 << (61 - fb))) >> (62 - fb);
        lim = (64'd1 << fb) - 64'd1;
        if (ent > lim) begin
            ent = lim;
        end
        return ent[31:0];
    endfunction

endpackage

>>> rtl/core/e2q_sincos.sv
// Half-angle sine and cosine of one binary angle, three register stages deep.
// Uses the quarter-wave table built by e2q_pkg::e2q_sin_entry.
// Depends on e2q_pkg.
module e2q_sincos
    import e2q_pkg::*;
#(
    parameter int ANGLE_BITS       = E2Q_ANGLE_BITS,
    parameter int TABLE_INDEX_BITS = E2Q_TABLE_INDEX_BITS,
    parameter int FRAC_BITS        = E2Q_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic [ANGLE_BITS-1:0]       i_angle,
    output logic signed [FRAC_BITS:0]   o_sin,
    output logic signed [FRAC_BITS:0]   o_cos
);

    localparam int TBL_LEN = (1 << TABLE_INDEX_BITS) + 1;
    localparam int KW      = TABLE_INDEX_BITS + 1;
    localparam int SHIFT   = ANGLE_BITS - 1 - TABLE_INDEX_BITS;
    localparam logic [KW-1:0] FULL_IDX = KW'(TBL_LEN - 1);

    // Constant quarter-wave table; synthesis folds it into a ROM.
    logic [FRAC_BITS-1:0] w_tbl [TBL_LEN];

    for (genvar g = 0; g < TBL_LEN; g++) begin : g_tbl
        localparam logic [FRAC_BITS-1:0] ENTRY =
            FRAC_BITS'(e2q_sin_entry(g, TABLE_INDEX_BITS, FRAC_BITS));
        assign w_tbl[g] = ENTRY;
    end

    // Magnitude of the angle and the table index; the index never exceeds the last entry.
    logic                  w_neg;
    logic [ANGLE_BITS-1:0] w_mag;
    logic [KW-1:0]         w_k;

    assign w_neg = i_angle[ANGLE_BITS-1];
    assign w_mag = w_neg ? (ANGLE_BITS'(0) - i_angle) : i_angle;

    if (SHIFT >= 0) begin : g_shr
        assign w_k = KW'(w_mag >> SHIFT);
    end else begin : g_shl
        assign w_k = KW'({w_mag, {(-SHIFT){1'b0}}});
    end

    logic [KW-1:0]        r_k_sin;
    logic [KW-1:0]        r_k_cos;
    logic                 r_neg1;
    logic [FRAC_BITS-1:0] r_sin_mag;
    logic [FRAC_BITS-1:0] r_cos_mag;
    logic                 r_neg2;
    logic signed [FRAC_BITS:0] r_sin;
    logic signed [FRAC_BITS:0] r_cos;

    // Stage one: indexes; stage two: table reads; stage three: sine takes the angle's sign.
    always_ff @(posedge i_clk) begin
        r_k_sin   <= w_k;
        r_k_cos   <= FULL_IDX - w_k;
        r_neg1    <= w_neg;
        r_sin_mag <= w_tbl[r_k_sin];
        r_cos_mag <= w_tbl[r_k_cos];
        r_neg2    <= r_neg1;
        r_sin     <= r_neg2 ? -$signed({1'b0, r_sin_mag}) : $signed({1'b0, r_sin_mag});
        r_cos     <= $signed({1'b0, r_cos_mag});
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

>>> rtl/core/euler_to_quaternion_core.sv
// Top level of the Euler angle to quaternion core (ZYX order), fixed-point pipeline.
// Instantiates three e2q_sincos units and forms the four components.
// Depends on e2q_pkg and e2q_sincos.
//
// Usage:
//   A transaction carries pitch, yaw and roll as signed binary angles, where
//   2^(ANGLE_BITS-1) stands for pi. It is accepted at a rising edge with start
//   high and busy low. busy is high only while reset is held; otherwise the
//   pipeline takes one transaction every cycle, with no gaps.
//   The quaternion w, x, y, z (signed, FRAC_BITS fraction bits) appears on the
//   result ports for one cycle, marked by o_result_valid, after the stages
//   below. Results leave in the order the angles entered.
//   The data pass eight register stages: table index, table read, sign, pair
//   products, split triple products, partial sums with the rounding constant,
//   full sum, and floor shift with saturation into the output register.
//   The receiver cannot stall, so nothing is held back; a result not taken in
//   its cycle is gone.
//   Reset clears the valid pipeline at the next edge, so no strobe appears for
//   angles accepted before reset; the table is constant and needs no fill.
module euler_to_quaternion_core
    import e2q_pkg::*;
#(
    parameter int ANGLE_BITS       = E2Q_ANGLE_BITS,
    parameter int TABLE_INDEX_BITS = E2Q_TABLE_INDEX_BITS,
    parameter int FRAC_BITS        = E2Q_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [ANGLE_BITS-1:0] i_pitch_angle,
    input  logic signed [ANGLE_BITS-1:0] i_yaw_angle,
    input  logic signed [ANGLE_BITS-1:0] i_roll_angle,
    output logic                        o_result_valid,
    output logic signed [FRAC_BITS:0]   o_quat_w,
    output logic signed [FRAC_BITS:0]   o_quat_x,
    output logic signed [FRAC_BITS:0]   o_quat_y,
    output logic signed [FRAC_BITS:0]   o_quat_z
);

    localparam int LAT = 8;
    localparam int VW  = FRAC_BITS + 1;           // sine or cosine
    localparam int PW  = 2 * FRAC_BITS + 2;       // pair product
    localparam int HW  = FRAC_BITS + 2;           // upper part of a pair product
    localparam int PHW = HW + VW;                 // upper part times third factor
    localparam int PLW = 2 * VW;                  // lower part times third factor
    localparam int HSW = PHW + 1;
    localparam int LSW = PLW + 2;
    localparam int SW  = 3 * FRAC_BITS + 5;
    localparam int RW  = SW - 2 * FRAC_BITS;
    localparam logic [3:0] SUB_MASK = 4'b1010;    // x and z take a difference
    localparam logic signed [LSW-1:0] ROUND = LSW'(1) <<< (2 * FRAC_BITS - 1);
    localparam logic signed [RW-1:0]  R_MAX = RW'((1 << FRAC_BITS) - 1);
    localparam logic signed [RW-1:0]  R_MIN = RW'(-(1 << FRAC_BITS));

    // No transaction is taken while reset is held.
    assign busy = !i_rst_n;

    // Stages one to three: half-angle sine and cosine of each angle.
    logic signed [VW-1:0] w_sp, w_cp, w_sy, w_cy, w_sr, w_cr;

    e2q_sincos #(
        .ANGLE_BITS(ANGLE_BITS), .TABLE_INDEX_BITS(TABLE_INDEX_BITS), .FRAC_BITS(FRAC_BITS)
    ) u_pitch (
        .i_clk(i_clk), .i_angle(i_pitch_angle), .o_sin(w_sp), .o_cos(w_cp)
    );

    e2q_sincos #(
        .ANGLE_BITS(ANGLE_BITS), .TABLE_INDEX_BITS(TABLE_INDEX_BITS), .FRAC_BITS(FRAC_BITS)
    ) u_yaw (
        .i_clk(i_clk), .i_angle(i_yaw_angle), .o_sin(w_sy), .o_cos(w_cy)
    );

    e2q_sincos #(
        .ANGLE_BITS(ANGLE_BITS), .TABLE_INDEX_BITS(TABLE_INDEX_BITS), .FRAC_BITS(FRAC_BITS)
    ) u_roll (
        .i_clk(i_clk), .i_angle(i_roll_angle), .o_sin(w_sr), .o_cos(w_cr)
    );

    // Valid bits travel beside the data.
    logic [LAT-1:0] r_valid;
    logic [LAT-1:0] n_valid;

    assign n_valid = {r_valid[LAT-2:0], start && !busy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Stage four: the four roll-pitch pair products, yaw delayed alongside.
    logic signed [PW-1:0] r_crcp, r_srsp, r_srcp, r_crsp;
    logic signed [VW-1:0] r_sy4, r_cy4;

    always_ff @(posedge i_clk) begin
        r_crcp <= w_cr * w_cp;
        r_srsp <= w_sr * w_sp;
        r_srcp <= w_sr * w_cp;
        r_crsp <= w_cr * w_sp;
        r_sy4  <= w_sy;
        r_cy4  <= w_cy;
    end

    // Operands of each component: (pair a times yaw a) plus or minus (pair b times yaw b).
    logic signed [PW-1:0] w_pa [4];
    logic signed [PW-1:0] w_pb [4];
    logic signed [VW-1:0] w_ya [4];
    logic signed [VW-1:0] w_yb [4];

    assign w_pa[0] = r_crcp;  assign w_ya[0] = r_cy4;
    assign w_pb[0] = r_srsp;  assign w_yb[0] = r_sy4;
    assign w_pa[1] = r_srcp;  assign w_ya[1] = r_cy4;
    assign w_pb[1] = r_crsp;  assign w_yb[1] = r_sy4;
    assign w_pa[2] = r_crsp;  assign w_ya[2] = r_cy4;
    assign w_pb[2] = r_srcp;  assign w_yb[2] = r_sy4;
    assign w_pa[3] = r_crcp;  assign w_ya[3] = r_sy4;
    assign w_pb[3] = r_srsp;  assign w_yb[3] = r_cy4;

    logic signed [FRAC_BITS:0] r_quat [4];

    for (genvar c = 0; c < 4; c++) begin : g_comp
        // Split each pair product into a signed upper part and an unsigned lower part,
        // so every multiplier stays narrow and the triple product stays exact.
        logic signed [HW-1:0]  w_hi_a, w_hi_b;
        logic signed [VW-1:0]  w_lo_a, w_lo_b;
        logic signed [PHW-1:0] r_ph_a, r_ph_b;
        logic signed [PLW-1:0] r_pl_a, r_pl_b;
        logic signed [HSW-1:0] r_hs;
        logic signed [LSW-1:0] r_ls;
        logic signed [SW-1:0]  r_sum;
        logic signed [RW-1:0]  w_q;

        assign w_hi_a = HW'(w_pa[c] >>> FRAC_BITS);
        assign w_hi_b = HW'(w_pb[c] >>> FRAC_BITS);
        assign w_lo_a = {1'b0, w_pa[c][FRAC_BITS-1:0]};
        assign w_lo_b = {1'b0, w_pb[c][FRAC_BITS-1:0]};
        assign w_q    = RW'(r_sum >>> (2 * FRAC_BITS));

        always_ff @(posedge i_clk) begin
            // Stage five: partial triple products.
            r_ph_a <= w_hi_a * w_ya[c];
            r_ph_b <= w_hi_b * w_yb[c];
            r_pl_a <= w_lo_a * w_ya[c];
            r_pl_b <= w_lo_b * w_yb[c];
            // Stage six: upper and lower sums, rounding constant added low.
            if (SUB_MASK[c]) begin
                r_hs <= HSW'(r_ph_a) - HSW'(r_ph_b);
                r_ls <= LSW'(r_pl_a) - LSW'(r_pl_b) + ROUND;
            end else begin
                r_hs <= HSW'(r_ph_a) + HSW'(r_ph_b);
                r_ls <= LSW'(r_pl_a) + LSW'(r_pl_b) + ROUND;
            end
            // Stage seven: full-precision sum.
            r_sum <= (SW'(r_hs) <<< FRAC_BITS) + SW'(r_ls);
            // Stage eight: floor shift and saturation into the output register.
            if (w_q > R_MAX) begin
                r_quat[c] <= R_MAX[FRAC_BITS:0];
            end else if (w_q < R_MIN) begin
                r_quat[c] <= R_MIN[FRAC_BITS:0];
            end else begin
                r_quat[c] <= w_q[FRAC_BITS:0];
            end
        end
    end

    assign o_result_valid = r_valid[LAT-1];
    assign o_quat_w       = r_quat[0];
    assign o_quat_x       = r_quat[1];
    assign o_quat_y       = r_quat[2];
    assign o_quat_z       = r_quat[3];

    // Every accepted transaction yields a result strobe.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_result_valid)
        else $error("accepted transaction produced no result");

    // No result appears without a matching earlier start.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start, LAT))
        else $error("result strobe without an accepted transaction");

    // With pitch and yaw both zero, the y and z components vanish.
    a_zero_pitch_yaw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && $past(i_pitch_angle == '0 && i_yaw_angle == '0, LAT))
        |-> (o_quat_y == '0 && o_quat_z == '0))
        else $error("nonzero y or z for zero pitch and yaw");

endmodule
